// ----- src/yuyv_pkg.sv -----
// Shared types, widths and constants for the packed YUYV to RGB24 converter.
// Used by yuyv_chroma, yuyv_lane and packed_yuyv_to_rgb24; no dependencies.
package yuyv_pkg;

  localparam int PIX_W  = 8;          // one sample / one color byte
  localparam int TERM_W = 10;         // signed chroma term, -227..225
  localparam int SUM_W  = 12;         // signed luma + term before clamp
  localparam int IN_W   = 4 * PIX_W;  // packed macropixel
  localparam int OUT_W  = 6 * PIX_W;  // two 24-bit pixels

  // Fixed-point chroma gains (Q8)
  localparam logic signed [TERM_W-1:0] K_RED  = 10'sd359;
  localparam logic signed [TERM_W-1:0] K_BLUE = 10'sd454;
  localparam logic signed [TERM_W-1:0] K_GV   = 10'sd183;
  localparam logic signed [TERM_W-1:0] K_GU   = 10'sd88;
  localparam logic [PIX_W-1:0]         CHROMA_BIAS = 8'd128;
  localparam logic [PIX_W-1:0]         PIX_MAX     = 8'd255;

  // Chroma terms shared by both pixels of a macropixel
  typedef struct packed {
    logic signed [TERM_W-1:0] red;
    logic signed [TERM_W-1:0] green;  // subtracted from luma
    logic signed [TERM_W-1:0] blue;
  } chroma_terms_t;

  // One converted pixel
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_pix_t;

  // Clamp a signed sum to 0..255
  function automatic logic [PIX_W-1:0] sat8(input logic signed [SUM_W-1:0] x);
    logic [PIX_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > $signed({{(SUM_W-PIX_W){1'b0}}, PIX_MAX})) begin
      res = PIX_MAX;
    end else begin
      res = x[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- src/packed_yuyv_to_rgb24.sv -----
// Packed YUYV 4:2:2 to RGB24/BGR24 converter, one macropixel per transaction.
// Registered stages from input transaction to out_tvalid: chroma multiply,
// pixel lanes, byte-order output register. Throughput: 1 macropixel/cycle while
// out_tready holds; each stage loads whenever the next one is empty or moving.
// Reset (rst_n low, synchronous): pipeline empties, blue_first returns to 0.
// Depends on yuyv_pkg, yuyv_chroma, yuyv_lane.
module packed_yuyv_to_rgb24 (
  input  logic                         clk,
  input  logic                         rst_n,
  // cfg: blue_first
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  // in: [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [yuyv_pkg::IN_W-1:0]    in_tdata,
  // out: [7:0] pixel_a_byte0, [15:8] pixel_a_byte1, [23:16] pixel_a_byte2,
  //      [31:24] pixel_b_byte0, [39:32] pixel_b_byte1, [47:40] pixel_b_byte2
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [yuyv_pkg::OUT_W-1:0]   out_tdata
);
  import yuyv_pkg::*;

  logic                 blue_first_r;
  logic                 s1_v_r;
  logic                 s2_v_r;
  logic                 out_v_r;
  logic                 out_adv;
  logic                 s2_adv;
  logic                 s1_adv;
  logic [PIX_W-1:0]     luma_a_r;
  logic [PIX_W-1:0]     luma_b_r;
  chroma_terms_t        terms;
  rgb_pix_t             pix_a;
  rgb_pix_t             pix_b;
  logic [OUT_W-1:0]     out_data_nxt;
  logic [OUT_W-1:0]     out_data_r;

  // Stage enables: a stage loads when the one after it is empty or moving
  assign out_adv   = !out_v_r || out_tready;
  assign s2_adv    = !s2_v_r  || out_adv;
  assign s1_adv    = !s1_v_r  || s2_adv;
  assign in_tready = s1_adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_first_r <= 1'b0;
    end else if (cfg_wr_en) begin
      blue_first_r <= cfg_wr_data;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv)  s1_v_r  <= in_tvalid;
      if (s2_adv)  s2_v_r  <= s1_v_r;
      if (out_adv) out_v_r <= s2_v_r;
    end
  end

  // Stage 1: chroma terms plus delayed luma samples
  yuyv_chroma u_chroma (
    .clk         (clk),
    .en          (s1_adv),
    .chroma_blue (in_tdata[2*PIX_W-1:PIX_W]),
    .chroma_red  (in_tdata[4*PIX_W-1:3*PIX_W]),
    .terms       (terms)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      luma_a_r <= in_tdata[PIX_W-1:0];
      luma_b_r <= in_tdata[3*PIX_W-1:2*PIX_W];
    end
  end

  // Stage 2: one lane per pixel
  yuyv_lane u_lane_a (
    .clk   (clk),
    .en    (s2_adv),
    .luma  (luma_a_r),
    .terms (terms),
    .pix   (pix_a)
  );

  yuyv_lane u_lane_b (
    .clk   (clk),
    .en    (s2_adv),
    .luma  (luma_b_r),
    .terms (terms),
    .pix   (pix_b)
  );

  // Merge: apply byte order and pack both pixels
  always_comb begin
    if (blue_first_r) begin
      out_data_nxt = {pix_b.red, pix_b.green, pix_b.blue,
                      pix_a.red, pix_a.green, pix_a.blue};
    end else begin
      out_data_nxt = {pix_b.blue, pix_b.green, pix_b.red,
                      pix_a.blue, pix_a.green, pix_a.red};
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // An accepted macropixel always lands in stage 1
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_v_r)
    else $error("accepted transaction missing from stage 1");

  // A full stage 2 moving forward always fills the output register
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_adv) |=> out_v_r)
    else $error("lane result dropped before output register");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !s1_v_r && !s2_v_r))
    else $error("pipeline not empty after reset");

endmodule

// ----- src/yuyv_chroma.sv -----
// Chroma term stage: constant multiplies of U and V, floored by an arithmetic
// shift of 8, registered. Depends on yuyv_pkg.
module yuyv_chroma (
  input  logic                          clk,
  input  logic                          en,
  input  logic [yuyv_pkg::PIX_W-1:0]    chroma_blue,
  input  logic [yuyv_pkg::PIX_W-1:0]    chroma_red,
  output yuyv_pkg::chroma_terms_t       terms
);
  import yuyv_pkg::*;

  localparam int PROD_W = PIX_W + 1 + TERM_W;

  logic signed [PIX_W:0]    u_c;
  logic signed [PIX_W:0]    v_c;
  logic signed [PROD_W-1:0] p_red;
  logic signed [PROD_W-1:0] p_blue;
  logic signed [PROD_W-1:0] p_gv;
  logic signed [PROD_W-1:0] p_gu;
  logic signed [TERM_W-1:0] t_gv;
  logic signed [TERM_W-1:0] t_gu;
  chroma_terms_t            terms_nxt;
  chroma_terms_t            terms_r;

  // Remove the offset-binary bias
  assign u_c = $signed({1'b0, chroma_blue}) - $signed({1'b0, CHROMA_BIAS});
  assign v_c = $signed({1'b0, chroma_red})  - $signed({1'b0, CHROMA_BIAS});

  // Constant products
  assign p_red  = PROD_W'(v_c) * PROD_W'(K_RED);
  assign p_blue = PROD_W'(u_c) * PROD_W'(K_BLUE);
  assign p_gv   = PROD_W'(v_c) * PROD_W'(K_GV);
  assign p_gu   = PROD_W'(u_c) * PROD_W'(K_GU);

  // Floor by >>> 8: the kept bits hold every reachable value
  assign t_gv = TERM_W'(p_gv >>> 8);
  assign t_gu = TERM_W'(p_gu >>> 8);

  always_comb begin
    terms_nxt.red   = TERM_W'(p_red >>> 8);
    terms_nxt.blue  = TERM_W'(p_blue >>> 8);
    terms_nxt.green = t_gv + t_gu;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms = terms_r;

endmodule

// ----- src/yuyv_lane.sv -----
// One pixel lane: adds the shared red and blue chroma terms to a luma sample,
// subtracts the green term, and clamps each channel to 0..255, registered. Depends on yuyv_pkg.
module yuyv_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [yuyv_pkg::PIX_W-1:0]  luma,
  input  yuyv_pkg::chroma_terms_t     terms,
  output yuyv_pkg::rgb_pix_t          pix
);
  import yuyv_pkg::*;

  logic signed [SUM_W-1:0] y_s;
  logic signed [SUM_W-1:0] r_sum;
  logic signed [SUM_W-1:0] g_sum;
  logic signed [SUM_W-1:0] b_sum;
  rgb_pix_t                pix_nxt;
  rgb_pix_t                pix_r;

  assign y_s   = $signed({{(SUM_W-PIX_W){1'b0}}, luma});
  assign r_sum = y_s + SUM_W'(terms.red);
  assign g_sum = y_s - SUM_W'(terms.green);
  assign b_sum = y_s + SUM_W'(terms.blue);

  always_comb begin
    pix_nxt.red   = sat8(r_sum);
    pix_nxt.green = sat8(g_sum);
    pix_nxt.blue  = sat8(b_sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix = pix_r;

endmodule
